// ===== rtl/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// mtf_pkg
// shared types, codes and constants of the move-to-front list core
// ----------------------------------------------------------------------------
package mtf_pkg;

    // default list capacity
    localparam int CAPACITY_DEF = 16;

    // payload widths
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_HEAD,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic                load;        // capture key, clear index
        logic                ins_wr;      // append request value at tail
        logic                rd_prev;     // read address is index minus one
        logic                idx_inc;
        logic                idx_dec;
        logic                wr_shift;    // write read data at index
        logic                wr_head;     // write key at head
        logic                status_we;
        logic [STATUS_W-1:0] status_code;
        logic                out_load;    // move status into output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_search;
        logic full;
        logic empty;
        logic match;
        logic last;
        logic idx_zero;
        logic idx_one;
    } t_dp_stat;

endpackage

// ===== rtl/mtf_if.sv =====
// ----------------------------------------------------------------------------
// mtf_if
// request and response channels of the move-to-front list core
// ----------------------------------------------------------------------------
interface mtf_req_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [mtf_pkg::DATA_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface mtf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mtf_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

// ===== rtl/mtf_ram.sv =====
// ----------------------------------------------------------------------------
// mtf_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtf_ctrl
// sequencer for insert, scan and move-to-front shift
// ----------------------------------------------------------------------------
module mtf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mtf_pkg::t_dp_stat i_stat,
    output mtf_pkg::t_dp_cmd  o_cmd
);

    mtf_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            mtf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.in_search) begin
                        o_cmd.status_we = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.status_code = mtf_pkg::ST_FULL;
                        end else begin
                            o_cmd.ins_wr      = 1'b1;
                            o_cmd.status_code = mtf_pkg::ST_OK;
                        end
                        n_state = mtf_pkg::S_DONE;
                    end else if (i_stat.empty) begin
                        o_cmd.status_we   = 1'b1;
                        o_cmd.status_code = mtf_pkg::ST_NOT_FOUND;
                        n_state           = mtf_pkg::S_DONE;
                    end else begin
                        n_state = mtf_pkg::S_SCAN;
                    end
                end
            end
            mtf_pkg::S_SCAN: begin
                n_state = mtf_pkg::S_CMP;
            end
            mtf_pkg::S_CMP: begin
                if (i_stat.match) begin
                    if (i_stat.idx_zero) begin
                        o_cmd.status_we   = 1'b1;
                        o_cmd.status_code = mtf_pkg::ST_OK;
                        n_state           = mtf_pkg::S_DONE;
                    end else begin
                        n_state = mtf_pkg::S_SHIFT_RD;
                    end
                end else if (i_stat.last) begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = mtf_pkg::ST_NOT_FOUND;
                    n_state           = mtf_pkg::S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = mtf_pkg::S_SCAN;
                end
            end
            mtf_pkg::S_SHIFT_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = mtf_pkg::S_SHIFT_WR;
            end
            mtf_pkg::S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_dec  = 1'b1;
                n_state        = i_stat.idx_one ? mtf_pkg::S_HEAD : mtf_pkg::S_SHIFT_RD;
            end
            mtf_pkg::S_HEAD: begin
                o_cmd.wr_head     = 1'b1;
                o_cmd.status_we   = 1'b1;
                o_cmd.status_code = mtf_pkg::ST_OK;
                n_state           = mtf_pkg::S_DONE;
            end
            mtf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = mtf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // the output register is never overwritten while a result still waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    // a shift write is always followed by a read or the head write
    a_shift_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_shift |=> (r_state == mtf_pkg::S_SHIFT_RD || r_state == mtf_pkg::S_HEAD))
        else $error("shift sequence broken");
`endif

endmodule

// ===== rtl/mtf_dpath.sv =====
// ----------------------------------------------------------------------------
// mtf_dpath
// list storage, entry count, scan index and result register
// ----------------------------------------------------------------------------
module mtf_dpath #(
    parameter int CAPACITY = mtf_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_command,
    input  logic signed [mtf_pkg::DATA_W-1:0] i_value,
    input  mtf_pkg::t_dp_cmd                  i_cmd,
    output mtf_pkg::t_dp_stat                 o_stat,
    output logic [mtf_pkg::STATUS_W-1:0]      o_status
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]            r_count;
    logic [ADDR_W-1:0]           r_idx;
    logic [mtf_pkg::DATA_W-1:0]  r_key;
    logic [mtf_pkg::STATUS_W-1:0] r_status;
    logic [mtf_pkg::STATUS_W-1:0] r_out_status;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [mtf_pkg::DATA_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [mtf_pkg::DATA_W-1:0]  ram_rdata;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.ins_wr) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + ADDR_W'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - ADDR_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_value;
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
        end
    end

    // write port: append, shift back, or key to head
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = r_key;
        priority if (i_cmd.ins_wr) begin
            ram_waddr = r_count[ADDR_W-1:0];
            ram_wdata = i_value;
        end else if (i_cmd.wr_shift) begin
            ram_waddr = r_idx;
            ram_wdata = ram_rdata;
        end else if (i_cmd.wr_head) begin
            ram_waddr = '0;
            ram_wdata = r_key;
        end else begin
            ram_we = 1'b0;
        end
    end

    assign ram_raddr = i_cmd.rd_prev ? (r_idx - ADDR_W'(1)) : r_idx;

    mtf_ram #(
        .WIDTH (mtf_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_stat.in_search = (i_command == mtf_pkg::CMD_SEARCH);
        o_stat.full      = (r_count == CNT_W'(CAPACITY));
        o_stat.empty     = (r_count == '0);
        o_stat.match     = (ram_rdata == r_key);
        o_stat.last      = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
        o_stat.idx_zero  = (r_idx == '0);
        o_stat.idx_one   = (r_idx == ADDR_W'(1));
    end

    assign o_status = r_out_status;

`ifndef SYNTHESIS
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_wr |-> (r_count < CNT_W'(CAPACITY)))
        else $error("append into a full list");

    a_shift_not_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_shift |-> (r_idx != '0))
        else $error("shift write at head position");

    a_search_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && o_stat.in_search) |=> (r_count == $past(r_count)))
        else $error("search changed the entry count");
`endif

endmodule

// ===== rtl/move_to_front_list_core.sv =====
// ----------------------------------------------------------------------------
// move_to_front_list_core
// self-organizing list with append and move-to-front search
// ----------------------------------------------------------------------------
// i_req carries one request: command (insert or search) and a signed value.
// o_rsp returns exactly one status per request: ok, not found, or full.
// an insert appends at the tail; when the list already holds CAPACITY
// entries it is dropped and reports full. a search scans from the head,
// takes the first equal entry, moves it to the front and shifts the
// entries ahead of it back by one place.
// requests are handled one at a time; the list sits in a single RAM with
// one write and one registered read port. an insert, or a search on an
// empty list, goes straight to the result load; a search reads and then
// compares each entry from the head, and on a hit below the head reads
// and writes back each entry ahead of it, writes the key at the head and
// then loads the result. the next request is taken in the cycle after the
// previous status is loaded, even while that status still waits in the
// output register; a stalled receiver holds the block in its final step
// until the register frees up.
// reset empties the list (count cleared); list storage is not cleared.
// ----------------------------------------------------------------------------
module move_to_front_list_core #(
    parameter int CAPACITY = mtf_pkg::CAPACITY_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mtf_req_if.sink   i_req,
    mtf_rsp_if.source o_rsp
);

    mtf_pkg::t_dp_cmd  cmd;
    mtf_pkg::t_dp_stat stat;

    // sequencer: accepts requests, steps through scan and shift
    mtf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage, count, index and status register
    mtf_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_command (i_req.command),
        .i_value   (i_req.value),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_status  (o_rsp.status)
    );

`ifndef SYNTHESIS
    // a request is only taken when no earlier request is still in flight
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted back to back");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking regression of the move-to-front list core
// ----------------------------------------------------------------------------
// a queue of requests feeds a clocked driver; each accepted request runs
// through a behavioral list model (append at tail, first-match search with
// move to front) and its predicted status is queued. a clocked monitor
// checks every response against the oldest prediction. a short directed
// sequence covers the empty list, extreme values, duplicates, head and tail
// hits and the full list. random requests follow, mostly searches for keys
// that are known to be present, plus near misses and random keys, under
// three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIST_CAP     = mtf_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 4 * LIST_CAP + 16;

    typedef struct packed {
        logic                       command;
        logic [mtf_pkg::DATA_W-1:0] value;
    } t_mtf_request;

    logic i_clk;
    logic rst_n;

    mtf_req_if req_bus ();
    mtf_rsp_if rsp_bus ();

    move_to_front_list_core #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // stimulus and scoreboard storage
    t_mtf_request                 pending_requests[$];
    logic [mtf_pkg::STATUS_W-1:0] expected_status[$];
    logic [mtf_pkg::DATA_W-1:0]   known_keys[$];      // members of the list, order ignored

    // list model in request-acceptance order
    logic [mtf_pkg::DATA_W-1:0] list_model [LIST_CAP];
    int                         list_len;

    int send_idle_pct;
    int recv_stall_pct;
    int queued_count;
    int accepted_count;
    int checked_count;
    int error_count;
    int insert_count;
    int full_drops;
    int search_hits;
    int search_misses;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // advance the list model by one request and return its status
    function automatic logic [mtf_pkg::STATUS_W-1:0] predict_status(
        logic command, logic [mtf_pkg::DATA_W-1:0] key);
        int hit;
        hit = -1;
        if (command == mtf_pkg::CMD_INSERT) begin
            insert_count++;
            if (list_len >= LIST_CAP) begin
                full_drops++;
                return mtf_pkg::ST_FULL;
            end
            list_model[list_len] = key;
            list_len++;
            return mtf_pkg::ST_OK;
        end
        for (int i = 0; i < list_len; i++)
            if (hit < 0 && list_model[i] == key)
                hit = i;
        if (hit < 0) begin
            search_misses++;
            return mtf_pkg::ST_NOT_FOUND;
        end
        // entries ahead of the hit slide back one place
        for (int j = hit; j > 0; j--)
            list_model[j] = list_model[j-1];
        list_model[0] = key;
        search_hits++;
        return mtf_pkg::ST_OK;
    endfunction

    task automatic push_request(logic command, logic [mtf_pkg::DATA_W-1:0] value);
        t_mtf_request req;
        req.command = command;
        req.value   = value;
        pending_requests.push_back(req);
        queued_count++;
        if (command == mtf_pkg::CMD_INSERT && known_keys.size() < LIST_CAP)
            known_keys.push_back(value);
    endtask

    function automatic logic [mtf_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return {1'b1, {(mtf_pkg::DATA_W-1){1'b0}}};
            1:       return {1'b0, {(mtf_pkg::DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_requests(int n);
        int roll;
        logic [mtf_pkg::DATA_W-1:0] key;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 8 || (known_keys.size() < LIST_CAP && roll < 40)) begin
                push_request(mtf_pkg::CMD_INSERT, pick_value());
            end else begin
                roll = $urandom_range(99);
                if (known_keys.size() == 0 || roll < 15) begin
                    key = pick_value();
                end else begin
                    key = known_keys[$urandom_range(known_keys.size() - 1)];
                    // near miss: one bit off a stored value
                    if (roll < 30)
                        key[$urandom_range(mtf_pkg::DATA_W - 1)] ^= 1'b1;
                end
                push_request(mtf_pkg::CMD_SEARCH, key);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || accepted_count != queued_count
               || expected_status.size() != 0)
            @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin : request_driver
        t_mtf_request next_req;
        if (!rst_n) begin
            req_bus.valid   <= 1'b0;
            req_bus.command <= mtf_pkg::CMD_INSERT;
            req_bus.value   <= '0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_status.push_back(predict_status(req_bus.command, req_bus.value));
                accepted_count++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    req_bus.valid   <= 1'b1;
                    req_bus.command <= next_req.command;
                    req_bus.value   <= next_req.value;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin : status_monitor
        logic [mtf_pkg::STATUS_W-1:0] want;
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_status.size() == 0) begin
                    $error("status: unexpected response, expected none, actual %0d",
                           rsp_bus.status);
                    error_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (rsp_bus.status !== want) begin
                        $error("status: expected %0d, actual %0d", want, rsp_bus.status);
                        error_count++;
                    end
                    checked_count++;
                end
            end
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        rst_n           = 1'b0;
        list_len        = 0;
        queued_count    = 0;
        accepted_count  = 0;
        checked_count   = 0;
        error_count     = 0;
        insert_count    = 0;
        full_drops      = 0;
        search_hits     = 0;
        search_misses   = 0;
        send_idle_pct   = 9;
        recv_stall_pct  = 86;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // search on the empty list
        push_request(mtf_pkg::CMD_SEARCH, '0);
        // extremes and duplicates
        push_request(mtf_pkg::CMD_INSERT, 32'h7FFF_FFFF);
        push_request(mtf_pkg::CMD_INSERT, 32'h8000_0000);
        push_request(mtf_pkg::CMD_INSERT, 32'h0000_0000);
        push_request(mtf_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        push_request(mtf_pkg::CMD_INSERT, 32'd5);
        push_request(mtf_pkg::CMD_INSERT, 32'd7);
        push_request(mtf_pkg::CMD_INSERT, 32'd5);
        // key at head stays put, then hits deeper in the list
        push_request(mtf_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
        push_request(mtf_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
        push_request(mtf_pkg::CMD_SEARCH, 32'h8000_0000);
        // only the first of the two fives moves
        push_request(mtf_pkg::CMD_SEARCH, 32'd5);
        push_request(mtf_pkg::CMD_SEARCH, 32'h1234_5678);
        // fill up, then append to a full list
        while (known_keys.size() < LIST_CAP)
            push_request(mtf_pkg::CMD_INSERT, $urandom);
        push_request(mtf_pkg::CMD_INSERT, 32'hA5A5_A5A5);
        push_request(mtf_pkg::CMD_SEARCH, known_keys[LIST_CAP-1]);
        push_request(mtf_pkg::CMD_SEARCH, 32'hDEAD_0001);

        queue_random_requests(RANDOM_ITEMS / 3);
        wait_drained();
        send_idle_pct  = 86;
        recv_stall_pct = 9;
        queue_random_requests(RANDOM_ITEMS / 3);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_requests(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_drained();
        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests: %0d inserts (%0d dropped on full list)",
                 accepted_count, insert_count, full_drops);
        $display("%0d searches found, %0d missed; %0d responses checked, %0d errors",
                 search_hits, search_misses, checked_count, error_count);
        if (error_count == 0)
            $display("move_to_front_list_core regression: pass");
        else
            $display("move_to_front_list_core regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("move_to_front_list_core regression: fail");
        $finish;
    end

endmodule
